// ===== src/isrt_pkg.sv =====
// Package for the insertion sorter: sizes, the element type and the control
// bundle that the top level drives into every cell of the chain.
// No dependencies.
`default_nettype none

package isrt_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  insert;
    logic  shift;
    word_t key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/isrt_ifs.sv =====
// Valid/ready channel interfaces for the insertion sorter's request and
// result streams.
// Depends on isrt_pkg.
`default_nettype none

interface isrt_in_if;
  logic                valid;
  logic                ready;
  isrt_pkg::word_t     value;
  logic                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface isrt_out_if;
  logic                valid;
  logic                ready;
  isrt_pkg::word_t     sorted_value;
  logic                end_of_set;
  logic                overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                output ready);
endinterface

`default_nettype wire

// ===== src/isrt_cell.sv =====
// One compare-and-shift cell of the sorting chain: holds one list entry,
// inserts from its lower neighbor and shifts down toward the output.
// Depends on isrt_pkg.
`default_nettype none

module isrt_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  isrt_pkg::cell_ctrl_t  ctrl,
  input  isrt_pkg::word_t       left_data,
  input  wire                   left_valid,
  input  wire                   left_gt,
  input  isrt_pkg::word_t       right_data,
  input  wire                   right_valid,
  output isrt_pkg::word_t       data,
  output logic                  valid,
  output logic                  gt
);

  isrt_pkg::word_t fill;

  assign gt   = valid && (data > ctrl.key);
  assign fill = left_gt ? left_data : ctrl.key;

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (gt || (!valid && left_valid)) begin
        data <= fill;
      end
    end else if (ctrl.shift) begin
      data <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (!valid && left_valid) begin
        valid <= 1'b1;
      end
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end
  end

endmodule

`default_nettype wire

// ===== src/insertion_sorter_core.sv =====
// Insertion sorter: sorts each set of signed 32-bit values arriving on the
// request stream and returns the set in ascending order on the result stream.
// Depends on isrt_pkg, isrt_ifs and isrt_cell.
//
// Requests are taken one per cycle; each is inserted into a chain of DEPTH
// cells in the cycle it is accepted, equal values keeping arrival order. The
// request marked is_last closes the set: from the next cycle the chain shifts
// its entries out through the output register, one result per cycle while the
// sink is ready. The request side is held off from the closing request until
// the final result of the set is loaded into the output register. Values
// arriving while all DEPTH cells are full are dropped, and every result of
// that set carries overflow.
`default_nettype none

module insertion_sorter_core (
  input  wire               clk,
  input  wire               rst,
  isrt_in_if.sink           in_ch,
  isrt_out_if.source        out_ch
);

  localparam int DEPTH = isrt_pkg::DEPTH;

  isrt_pkg::cell_ctrl_t ctrl;
  isrt_pkg::word_t      cell_data  [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_gt;

  logic draining;
  logic dropped;
  logic in_fire;
  logic out_load;
  logic full;

  assign full     = cell_valid[DEPTH-1];
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = draining && (!out_ch.valid || out_ch.ready);

  assign in_ch.ready = !draining;

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_load;
  assign ctrl.key    = in_ch.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    isrt_pkg::word_t l_data;
    logic            l_valid;
    logic            l_gt;
    isrt_pkg::word_t r_data;
    logic            r_valid;

    if (i == 0) begin : g_first
      assign l_data  = in_ch.value;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_inner
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    isrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (in_fire && full) begin
        dropped <= 1'b1;
      end
      if (in_fire && in_ch.is_last) begin
        draining <= 1'b1;
      end else if (out_load && !cell_valid[1]) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.sorted_value <= cell_data[0];
      out_ch.end_of_set   <= !cell_valid[1];
      out_ch.overflow     <= dropped;
    end
  end

endmodule

`default_nettype wire

// ===== src/isrt_checker.sv =====
// Port-level checks for the insertion sorter, bound to the top level.
// Depends on insertion_sorter_core and the channel interfaces.
`default_nettype none

module isrt_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire in_is_last,
  input wire out_valid,
  input wire out_ready,
  input wire out_end_of_set
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before it was taken.");

  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("Request accepted right after a set was closed.");

  a_mid_set_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_end_of_set |-> !in_ready)
    else $error("Request accepted while a set is still draining.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind insertion_sorter_core isrt_checker u_isrt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_is_last     (in_ch.is_last),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_end_of_set (out_ch.end_of_set)
);

`default_nettype wire

// ===== test/tb_insertion_sorter_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for insertion_sorter_core: directed table then random sets.
// Depends on isrt_pkg, isrt_ifs and insertion_sorter_core from the source folder.

module tb_insertion_sorter_core;

  typedef struct packed {
    isrt_pkg::word_t value;
    logic            eos;
    logic            ovf;
  } sort_result_t;

  typedef struct packed {
    isrt_pkg::word_t value;
    logic            last;
    logic            fixed;
    sort_result_t    want;
  } stim_row_t;

  localparam isrt_pkg::word_t WORD_MAX    = 32'sh7FFF_FFFF;
  localparam isrt_pkg::word_t WORD_MIN    = 32'sh8000_0000;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              LONG_HOLD   = 300;
  localparam int              TABLE_ROWS  = 25;

  // Single-element sets carry their result in the table; the rest go through the predictor.
  localparam stim_row_t SORT_TABLE [TABLE_ROWS] = '{
    '{WORD_MAX, 1'b1, 1'b1, '{WORD_MAX, 1'b1, 1'b0}},
    '{WORD_MIN, 1'b1, 1'b1, '{WORD_MIN, 1'b1, 1'b0}},
    '{32'sd0,   1'b1, 1'b1, '{32'sd0,   1'b1, 1'b0}},
    '{-32'sd1,  1'b1, 1'b1, '{-32'sd1,  1'b1, 1'b0}},
    '{WORD_MAX, 1'b0, 1'b0, '0}, '{-32'sd1,  1'b0, 1'b0, '0},
    '{-32'sd1,  1'b0, 1'b0, '0}, '{WORD_MIN, 1'b1, 1'b0, '0},
    '{32'sd3,   1'b0, 1'b0, '0}, '{32'sd7,   1'b0, 1'b0, '0},
    '{32'sd7,   1'b0, 1'b0, '0}, '{-32'sd5,  1'b0, 1'b0, '0},
    '{WORD_MAX, 1'b0, 1'b0, '0}, '{32'sd0,   1'b0, 1'b0, '0},
    '{32'sd12,  1'b0, 1'b0, '0}, '{-32'sd9,  1'b0, 1'b0, '0},
    '{32'sd7,   1'b0, 1'b0, '0}, '{32'sd1,   1'b0, 1'b0, '0},
    '{WORD_MIN, 1'b0, 1'b0, '0}, '{32'sd2,   1'b0, 1'b0, '0},
    '{-32'sd1,  1'b0, 1'b0, '0}, '{32'sd30,  1'b0, 1'b0, '0},
    '{32'sd5,   1'b0, 1'b0, '0}, '{-32'sd2,  1'b0, 1'b0, '0},
    '{-32'sd100, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  isrt_in_if  in_ch ();
  isrt_out_if out_ch ();

  insertion_sorter_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  isrt_pkg::word_t shadow_list [isrt_pkg::DEPTH];
  int              shadow_count = 0;
  logic            shadow_dropped = 1'b0;
  sort_result_t    flush_buf [isrt_pkg::DEPTH];
  sort_result_t    due_results [$];

  int   error_count = 0;
  int   cycle_count = 0;
  logic src_idle = 1'b0;
  logic snk_idle = 1'b0;
  logic long_hold_req = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_insertion_sorter_core: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40) begin
      $display("%0t: %s mismatch, got %h, want %h", $time, field, got, want);
    end
    error_count++;
  endtask

  // Inserts one request into the shadow list and returns how many results it releases.
  function automatic int insert_and_flush(input isrt_pkg::word_t v, input logic last);
    int pos;
    int n;
    if (shadow_count < isrt_pkg::DEPTH) begin
      pos = shadow_count;
      while (pos > 0 && shadow_list[pos-1] > v) begin
        shadow_list[pos] = shadow_list[pos-1];
        pos--;
      end
      shadow_list[pos] = v;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!last) begin
      return 0;
    end
    for (int k = 0; k < shadow_count; k++) begin
      flush_buf[k] = '{shadow_list[k], k == shadow_count - 1, shadow_dropped};
    end
    n = shadow_count;
    shadow_count = 0;
    shadow_dropped = 1'b0;
    return n;
  endfunction

  function automatic isrt_pkg::word_t random_value();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3, 4: return isrt_pkg::word_t'($urandom_range(0, 8)) - 32'sd4;
      default: return isrt_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic send_request(input isrt_pkg::word_t v, input logic last, input logic fixed,
                              input sort_result_t want);
    int gap;
    int n;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    n = insert_and_flush(v, last);
    if (fixed) begin
      due_results.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) due_results.push_back(flush_buf[k]);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(negedge clk);
    repeat (isrt_pkg::DEPTH + 4) @(negedge clk);
  endtask

  initial begin : result_sink
    int           gap;
    sort_result_t want;
    out_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = snk_idle ? $urandom_range(0, 15) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.sorted_value, '0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.sorted_value !== want.value) begin
          report_mismatch("sorted_value", out_ch.sorted_value, want.value);
        end
        if (out_ch.end_of_set !== want.eos) begin
          report_mismatch("end_of_set", 32'(out_ch.end_of_set), 32'(want.eos));
        end
        if (out_ch.overflow !== want.ovf) begin
          report_mismatch("overflow", 32'(out_ch.overflow), 32'(want.ovf));
        end
      end
      @(negedge clk);
    end
  end

  initial begin : request_source
    sort_result_t no_fixed;
    int           sent;
    int           set_len;
    int           pick;
    no_fixed = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < TABLE_ROWS; r++) begin
      send_request(SORT_TABLE[r].value, SORT_TABLE[r].last, SORT_TABLE[r].fixed,
                   SORT_TABLE[r].want);
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      src_idle = (phase == 0) || (phase == 3);
      snk_idle = (phase == 0) || (phase == 2);
      long_hold_req = (phase == 1);
      sent = 0;
      while (sent < 36) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          set_len = $urandom_range(1, 4);
        end else if (pick < 9) begin
          set_len = $urandom_range(5, isrt_pkg::DEPTH);
        end else begin
          set_len = $urandom_range(isrt_pkg::DEPTH + 1, isrt_pkg::DEPTH + 4);
        end
        for (int i = 0; i < set_len; i++) begin
          send_request(random_value(), i == set_len - 1, 1'b0, no_fixed);
        end
        sent += set_len;
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb_insertion_sorter_core: PASS");
    end else begin
      $display("tb_insertion_sorter_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/isrt_pkg.sv
src/isrt_ifs.sv
src/isrt_cell.sv
src/insertion_sorter_core.sv
src/isrt_checker.sv
test/tb_insertion_sorter_core.sv
